### hdl/reb_pkg.sv
// Shared types and constants for the rotary encoder and push switch decoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package reb_pkg;

  // Field widths.
  localparam int TIMER_W = 14;
  localparam int DEB_W   = 8;
  localparam int ACC_W   = 8;
  localparam int STEP_W  = 9;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 3;

  // Event codes on the input stream.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SWITCH = 2'd1;
  localparam logic [1:0] OP_PINS   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CLICK  = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;
  localparam logic [1:0] KIND_STEP   = 2'd3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [IDX_W-1:0] REG_DBL_WINDOW = 3'd2;
  localparam logic [IDX_W-1:0] REG_DBL_ENABLE = 3'd3;
  localparam logic [IDX_W-1:0] REG_ACC_ENABLE = 3'd4;
  localparam logic [IDX_W-1:0] REG_ACC_MAX    = 3'd5;
  localparam logic [IDX_W-1:0] REG_ACC_HOLD   = 3'd6;

  // Fixed decoding constants.
  localparam logic [TIMER_W-1:0] MIN_PRESS  = 14'd5;
  localparam logic [7:0]         SPLIT_CODE = 8'd20;
  localparam logic [7:0]         SCAN_LOW   = 8'h3f;
  localparam logic [7:0]         SCAN_HIGH  = 8'hc0;
  localparam logic [DEB_W-1:0]   DEB_SAT    = 8'd255;

  // Output queue sizing: one item yields at most two results.
  localparam int MAX_RESULTS = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_ticks;
    logic [TIMER_W-1:0] long_press_ticks;
    logic [TIMER_W-1:0] double_window_ticks;
    logic               double_enable;
  } key_cfg_t;

  typedef struct packed {
    logic             accel_enable;
    logic [ACC_W-1:0] accel_max;
    logic [ACC_W-1:0] accel_hold_ticks;
  } enc_cfg_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [STEP_W-1:0] step;
  } res_t;

  // Up to two results produced by one item, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [STEP_W-1:0] step;
    logic                     last;
  } entry_t;

endpackage

### hdl/reb_key.sv
// Push switch path: debounce, press timer, double-click window.
// Depends on reb_pkg.
`timescale 1ns / 1ps

module reb_key import reb_pkg::*; #(
  parameter int TIMER_IDLE = 10000
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic [1:0] opcode,
  input  logic      sw_level,
  input  key_cfg_t  cfg,
  output res_pair_t res
);

  localparam logic [TIMER_W-1:0] IDLE = TIMER_W'(TIMER_IDLE);

  logic               sw_sample, sw_sample_next;
  logic [DEB_W-1:0]   debounce_count, debounce_count_next;
  logic               sw_stable, sw_stable_next;
  logic [TIMER_W-1:0] press_timer, press_timer_next;
  logic [TIMER_W-1:0] double_timer, double_timer_next;
  logic [TIMER_W-1:0] expire;
  logic               long_hit, click_hit, double_hit;

  assign expire = cfg.double_enable ? cfg.double_window_ticks : TIMER_W'(1);

  // One tick or one switch change moves the key state forward.
  always_comb begin
    sw_sample_next      = sw_sample;
    debounce_count_next = debounce_count;
    sw_stable_next      = sw_stable;
    press_timer_next    = press_timer;
    double_timer_next   = double_timer;
    long_hit            = 1'b0;
    click_hit           = 1'b0;
    double_hit          = 1'b0;
    if (item_valid && opcode == OP_TICK) begin
      if (debounce_count != DEB_SAT) begin
        debounce_count_next = debounce_count + DEB_W'(1);
        if (debounce_count_next == cfg.debounce_ticks) begin
          sw_stable_next = sw_sample;
        end
      end
      if (!sw_stable_next && press_timer < IDLE) begin
        press_timer_next = press_timer + TIMER_W'(1);
        if (press_timer_next == cfg.long_press_ticks) begin
          long_hit = 1'b1;
        end
      end
      if (double_timer < IDLE) begin
        double_timer_next = double_timer + TIMER_W'(1);
        if (double_timer_next == expire) begin
          double_timer_next = IDLE;
          click_hit         = 1'b1;
        end
      end
      // Release: a press of proper length opens or closes the window.
      if (sw_stable_next) begin
        if (press_timer_next > MIN_PRESS && press_timer_next < cfg.long_press_ticks) begin
          if (double_timer_next > cfg.double_window_ticks) begin
            double_timer_next = '0;
          end else if (double_timer_next < cfg.double_window_ticks) begin
            double_timer_next = IDLE;
            double_hit        = 1'b1;
          end
        end
        press_timer_next = '0;
      end
    end else if (item_valid && opcode == OP_SWITCH) begin
      sw_sample_next      = sw_level;
      debounce_count_next = '0;
    end
  end

  // Order results: long press, then click, then double click.
  // Long press needs the switch held and double click needs it released,
  // so at most two are ever present.
  always_comb begin
    res.count = 2'd0;
    res.r0    = '{kind: KIND_CLICK, step: '0};
    res.r1    = '{kind: KIND_DOUBLE, step: '0};
    if (long_hit) begin
      res.r0    = '{kind: KIND_LONG, step: '0};
      res.r1    = '{kind: KIND_CLICK, step: '0};
      res.count = click_hit ? 2'd2 : 2'd1;
    end else if (click_hit) begin
      res.r0    = '{kind: KIND_CLICK, step: '0};
      res.count = double_hit ? 2'd2 : 2'd1;
    end else if (double_hit) begin
      res.r0    = '{kind: KIND_DOUBLE, step: '0};
      res.count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_sample      <= 1'b0;
      debounce_count <= '0;
      sw_stable      <= 1'b0;
      press_timer    <= IDLE;
      double_timer   <= IDLE;
    end else begin
      sw_sample      <= sw_sample_next;
      debounce_count <= debounce_count_next;
      sw_stable      <= sw_stable_next;
      press_timer    <= press_timer_next;
      double_timer   <= double_timer_next;
    end
  end

endmodule

### hdl/reb_enc.sv
// Quadrature path: phase scan, detent steps and acceleration.
// Depends on reb_pkg.
`timescale 1ns / 1ps

module reb_enc import reb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [1:0] opcode,
  input  logic       pin_a,
  input  logic       pin_b,
  input  enc_cfg_t   cfg,
  output logic       step_valid,
  output res_t       step_res
);

  logic [7:0]       scan_code, scan_code_next;
  logic [1:0]       last_phase, last_phase_next;
  logic [ACC_W-1:0] hold_left, hold_left_next;
  logic [ACC_W-1:0] accel_count, accel_count_next;
  logic             first_step, first_step_next;
  logic [1:0]       phase;
  logic [7:0]       scan_merged;
  logic [STEP_W-1:0] step_mag;

  assign phase       = {pin_b, pin_a};
  assign scan_merged = scan_code | {2'b00, phase, 4'b0000};
  assign step_mag    = {1'b0, accel_count} + STEP_W'(1);

  always_comb begin
    scan_code_next   = scan_code;
    last_phase_next  = last_phase;
    hold_left_next   = hold_left;
    accel_count_next = accel_count;
    first_step_next  = first_step;
    step_valid       = 1'b0;
    step_res.kind    = KIND_STEP;
    step_res.step    = (scan_merged < SPLIT_CODE) ? -$signed(step_mag) : $signed(step_mag);
    if (item_valid && opcode == OP_TICK) begin
      // Acceleration grows while the hold lasts.
      if (hold_left != '0) begin
        hold_left_next = hold_left - ACC_W'(1);
        if ({1'b0, accel_count} + (ACC_W+1)'(1) < {1'b0, cfg.accel_max}) begin
          accel_count_next = accel_count + ACC_W'(1);
        end
      end else begin
        accel_count_next = '0;
      end
    end else if (item_valid && opcode == OP_PINS) begin
      if (phase == 2'b00) begin
        scan_code_next = scan_code & SCAN_LOW;
      end else if (phase != 2'b11 && phase != last_phase) begin
        last_phase_next = phase;
        if ((scan_code & SCAN_HIGH) != 8'h00) begin
          scan_code_next = scan_code | {6'b000000, phase};
        end else begin
          // A detent completes; the very first one is swallowed.
          scan_code_next = SCAN_HIGH;
          if (first_step) begin
            first_step_next = 1'b0;
          end else begin
            step_valid = 1'b1;
            if (cfg.accel_enable) begin
              hold_left_next = cfg.accel_hold_ticks;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_code   <= '0;
      last_phase  <= '0;
      hold_left   <= '0;
      accel_count <= '0;
      first_step  <= 1'b1;
    end else begin
      scan_code   <= scan_code_next;
      last_phase  <= last_phase_next;
      hold_left   <= hold_left_next;
      accel_count <= accel_count_next;
      first_step  <= first_step_next;
    end
  end

endmodule

### hdl/reb_out_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per transfer.
// Depends on reb_pkg.
`timescale 1ns / 1ps

module reb_out_fifo import reb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_count,
  input  entry_t     wr_e0,
  input  entry_t     wr_e1,
  output logic       room,
  output logic       rd_valid,
  input  logic       rd_ready,
  output entry_t     rd_entry
);

  entry_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign rd_valid = count != '0;
  assign room     = count <= CNT_W'(FIFO_DEPTH - MAX_RESULTS);
  assign pop      = rd_valid && rd_ready;
  assign rd_entry = mem[rd_ptr];
  assign count_next = count + CNT_W'(wr_count) - CNT_W'(pop);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr_e0;
    end
    if (wr_count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= wr_e1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_write_fits: assert property (@(posedge clk) disable iff (rst)
    (wr_count != 2'd0) |-> ({1'b0, count} + (CNT_W+1)'(wr_count) <= (CNT_W+1)'(FIFO_DEPTH)))
    else $error("results written without room");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (wr_ptr - rd_ptr == count[PTR_W-1:0]))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

### hdl/rotary_encoder_button_decoder.sv
// Top level of the rotary encoder and push switch decoder.
// Depends on reb_pkg, reb_key, reb_enc and reb_out_fifo.
//
//  channel  | direction | signals                              | content
//  ---------+-----------+--------------------------------------+---------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser    | tick, switch or pin event
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser    | click/double/long/step
//           |           | m_tlast                              | last result of an event
//  cfg_*    | in        | cfg_we cfg_index cfg_data            | register writes
//
// Every event is decoded in the cycle it transfers; its zero to two results are
// written into a four-entry result queue at that edge and offered on m_* from
// the next cycle. s_tready is high while the queue holds two results or fewer,
// so events are taken one per clock until results pile up behind a stalled
// output; an event with two results adds one net entry even when m_* drains.
// rst is synchronous and active high; it clears all state and the queue.
`timescale 1ns / 1ps

module rotary_encoder_button_decoder import reb_pkg::*; #(
  parameter int TIMER_IDLE = 10000
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [0] sw_level, [1] pin_a, [2] pin_b, rest zero
  input  logic [1:0]       s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [8:0] step_value, rest zero
  output logic [1:0]       m_tuser,   // [1:0] event_kind
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  key_cfg_t  key_cfg;
  enc_cfg_t  enc_cfg;
  logic      item_valid;
  res_pair_t key_res;
  logic      step_valid;
  res_t      step_res;
  logic [1:0] wr_count;
  entry_t    wr_e0, wr_e1, rd_entry;
  logic      room;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg.debounce_ticks      <= 8'd10;
      key_cfg.long_press_ticks    <= 14'd1000;
      key_cfg.double_window_ticks <= 14'd300;
      key_cfg.double_enable       <= 1'b1;
      enc_cfg.accel_enable        <= 1'b0;
      enc_cfg.accel_max           <= 8'd10;
      enc_cfg.accel_hold_ticks    <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   key_cfg.debounce_ticks      <= cfg_data[DEB_W-1:0];
        REG_LONG_PRESS: key_cfg.long_press_ticks    <= cfg_data[TIMER_W-1:0];
        REG_DBL_WINDOW: key_cfg.double_window_ticks <= cfg_data[TIMER_W-1:0];
        REG_DBL_ENABLE: key_cfg.double_enable       <= cfg_data[0];
        REG_ACC_ENABLE: enc_cfg.accel_enable        <= cfg_data[0];
        REG_ACC_MAX:    enc_cfg.accel_max           <= cfg_data[ACC_W-1:0];
        REG_ACC_HOLD:   enc_cfg.accel_hold_ticks    <= cfg_data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready   = room;
  assign item_valid = s_tvalid && s_tready;

  reb_key #(.TIMER_IDLE(TIMER_IDLE)) u_key (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (s_tuser),
    .sw_level   (s_tdata[0]),
    .cfg        (key_cfg),
    .res        (key_res)
  );

  reb_enc u_enc (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .opcode     (s_tuser),
    .pin_a      (s_tdata[1]),
    .pin_b      (s_tdata[2]),
    .cfg        (enc_cfg),
    .step_valid (step_valid),
    .step_res   (step_res)
  );

  // Key and encoder results never come from the same event.
  always_comb begin
    if (key_res.count != 2'd0) begin
      wr_count = key_res.count;
      wr_e0    = '{kind: key_res.r0.kind, step: key_res.r0.step,
                   last: key_res.count == 2'd1};
    end else begin
      wr_count = step_valid ? 2'd1 : 2'd0;
      wr_e0    = '{kind: step_res.kind, step: step_res.step, last: 1'b1};
    end
    wr_e1 = '{kind: key_res.r1.kind, step: key_res.r1.step, last: 1'b1};
  end

  reb_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (wr_count),
    .wr_e0    (wr_e0),
    .wr_e1    (wr_e1),
    .room     (room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_entry (rd_entry)
  );

  assign m_tdata = {7'b0000000, rd_entry.step};
  assign m_tuser = rd_entry.kind;
  assign m_tlast = rd_entry.last;

endmodule

### verif/rotary_encoder_button_decoder_tb.sv
// Self-checking testbench for the rotary encoder and push switch decoder.
// Depends on reb_pkg and rotary_encoder_button_decoder; holds its own
// cycle-free model of the key timers and the quadrature decoder.
`timescale 1ns / 1ps

module rotary_encoder_button_decoder_tb;
  import reb_pkg::*;

  localparam int IDLE_TICKS      = 10000;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int NUM_PHASES      = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Predicts click, double click, long press and rotation results per event
  // and checks them against what the block delivers.
  class click_step_scoreboard #(int IDLE = 10000);
    // Register copies.
    bit [7:0]  deb_ticks;
    bit [13:0] long_ticks;
    bit [13:0] win_ticks;
    bit        dbl_en;
    bit        acc_en;
    bit [7:0]  acc_max;
    bit [7:0]  acc_hold;
    // Decoder state.
    bit        sw_sample;
    bit [7:0]  deb_cnt;
    bit        sw_stable;
    bit [13:0] press_t;
    bit [13:0] dbl_t;
    bit [7:0]  scan;
    bit [1:0]  last_ph;
    bit [7:0]  hold_left;
    bit [7:0]  acc_cnt;
    bit        first_detent;

    reb_pkg::entry_t expected_events[$];
    reb_pkg::entry_t item_results[$];
    int errors;

    function new();
      deb_ticks = 8'd10;
      long_ticks = 14'd1000;
      win_ticks = 14'd300;
      dbl_en = 1'b1;
      acc_en = 1'b0;
      acc_max = 8'd10;
      acc_hold = 8'd50;
      sw_sample = 1'b0;
      deb_cnt = 8'd0;
      sw_stable = 1'b0;
      press_t = 14'(IDLE);
      dbl_t = 14'(IDLE);
      scan = 8'd0;
      last_ph = 2'd0;
      hold_left = 8'd0;
      acc_cnt = 8'd0;
      first_detent = 1'b1;
      errors = 0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        reb_pkg::REG_DEBOUNCE:   deb_ticks = val[7:0];
        reb_pkg::REG_LONG_PRESS: long_ticks = val[13:0];
        reb_pkg::REG_DBL_WINDOW: win_ticks = val[13:0];
        reb_pkg::REG_DBL_ENABLE: dbl_en = val[0];
        reb_pkg::REG_ACC_ENABLE: acc_en = val[0];
        reb_pkg::REG_ACC_MAX:    acc_max = val[7:0];
        reb_pkg::REG_ACC_HOLD:   acc_hold = val[7:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [1:0] kind, logic signed [8:0] val);
      reb_pkg::entry_t e;
      e.kind = kind;
      e.step = val;
      e.last = 1'b0;
      item_results.push_back(e);
    endfunction

    // One millisecond tick: debounce, press timer, double window, acceleration.
    function void predict_tick();
      bit [13:0] expire;
      expire = dbl_en ? win_ticks : 14'd1;
      if (deb_cnt < 8'd255) begin
        deb_cnt++;
        if (deb_cnt == deb_ticks) sw_stable = sw_sample;
      end
      if (!sw_stable && press_t < IDLE) begin
        press_t++;
        if (press_t == long_ticks) emit(reb_pkg::KIND_LONG, 9'sd0);
      end
      if (dbl_t < IDLE) begin
        dbl_t++;
        if (dbl_t == expire) begin
          dbl_t = 14'(IDLE);
          emit(reb_pkg::KIND_CLICK, 9'sd0);
        end
      end
      if (sw_stable) begin
        if (press_t > 14'd5 && press_t < long_ticks) begin
          if (dbl_t > win_ticks) begin
            dbl_t = 14'd0;
          end else if (dbl_t < win_ticks) begin
            dbl_t = 14'(IDLE);
            emit(reb_pkg::KIND_DOUBLE, 9'sd0);
          end
        end
        press_t = 14'd0;
      end
      if (hold_left != 8'd0) begin
        hold_left--;
        if (int'(acc_cnt) < int'(acc_max) - 1) acc_cnt++;
      end else begin
        acc_cnt = 8'd0;
      end
    endfunction

    // A completed detent yields a signed step, except the very first one.
    function void predict_detent();
      int amount;
      if (first_detent) begin
        first_detent = 1'b0;
        return;
      end
      if (scan < 8'd20) amount = -1 - int'(acc_cnt);
      else amount = 1 + int'(acc_cnt);
      if (acc_en) hold_left = acc_hold;
      emit(reb_pkg::KIND_STEP, amount[8:0]);
    endfunction

    function void predict_pins(logic a, logic b);
      bit [1:0] ph;
      ph = {b, a};
      if (ph == 2'b11) return;
      if (ph == 2'b00) begin
        scan &= 8'h3f;
        return;
      end
      if (last_ph == ph) return;
      last_ph = ph;
      if ((scan & 8'hc0) != 8'd0) begin
        scan |= {6'd0, ph};
      end else begin
        scan = scan | {2'd0, ph, 4'd0};
        predict_detent();
        scan = 8'hc0;
      end
    endfunction

    // Called for every accepted input transfer.
    function void note_input(logic [1:0] op, logic sw, logic a, logic b);
      item_results.delete();
      case (op)
        reb_pkg::OP_TICK: predict_tick();
        reb_pkg::OP_SWITCH: begin
          sw_sample = sw;
          deb_cnt = 8'd0;
        end
        reb_pkg::OP_PINS: predict_pins(a, b);
        default: ;
      endcase
      if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
      foreach (item_results[i]) expected_events.push_back(item_results[i]);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Called for every accepted output transfer.
    task check_result(reb_pkg::entry_t got);
      reb_pkg::entry_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected result kind %0d step %0d last %0d",
                         got.kind, got.step, got.last));
        return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
      if (got.step !== want.step)
        report($sformatf("step_value %0d, want %0d", got.step, want.step));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'd0;
  logic [1:0]       s_tuser = 2'd0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  click_step_scoreboard #(IDLE_TICKS) sb;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int item_limit = 1000000;
  int idle_cycles = 0;
  int cur_deb, cur_long, cur_win, cur_hold;

  // Register settings per phase: debounce, long press, window, double enable,
  // accel enable, accel max, accel hold. Extremes and out-of-range values mixed in.
  int setting_tbl[NUM_PHASES][7] = '{
    '{1,   7,     2,     1, 1, 1,   0},
    '{3,   25,    12,    1, 1, 255, 255},
    '{2,   16,    16383, 1, 1, 0,   4},
    '{0,   3,     0,     0, 1, 3,   2},
    '{255, 16383, 9999,  1, 0, 10,  50},
    '{2,   14,    8,     0, 1, 6,   3},
    '{254, 9999,  9999,  0, 0, 2,   255},
    '{4,   30,    20,    1, 1, 20,  6}
  };

  rotary_encoder_button_decoder #(.TIMER_IDLE(IDLE_TICKS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Output side backpressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every output transfer.
  always @(posedge clk) begin : result_monitor
    reb_pkg::entry_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.step = m_tdata[8:0];
      got.last = m_tlast;
      sb.check_result(got);
    end
  end

  // Give up when nothing transfers for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic int span(int lim);
    int top;
    top = (lim > 40) ? 40 : lim;
    return $urandom_range(top, 0);
  endfunction

  function automatic logic rbit();
    return logic'($urandom_range(1));
  endfunction

  // One input transfer, with random idle cycles ahead of it. Once the item
  // budget of the current phase is used up, further events are dropped.
  task automatic send_event(logic [1:0] op, logic sw, logic a, logic b);
    if (items_sent >= item_limit) return;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'd0, b, a, sw};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, sw, a, b);
    items_sent++;
  endtask

  task automatic tick_burst(int n);
    repeat (n) send_event(OP_TICK, rbit(), rbit(), rbit());
  endtask

  // Hold the sender back until every expected result has been delivered.
  task automatic wait_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drain and let the last event work through before touching registers.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    sb.set_register(idx, val[CFG_W-1:0]);
  endtask

  task automatic apply_setting(int p);
    write_reg(REG_DEBOUNCE,   setting_tbl[p][0]);
    write_reg(REG_LONG_PRESS, setting_tbl[p][1]);
    write_reg(REG_DBL_WINDOW, setting_tbl[p][2]);
    write_reg(REG_DBL_ENABLE, setting_tbl[p][3]);
    write_reg(REG_ACC_ENABLE, setting_tbl[p][4]);
    write_reg(REG_ACC_MAX,    setting_tbl[p][5]);
    write_reg(REG_ACC_HOLD,   setting_tbl[p][6]);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_deb = setting_tbl[p][0];
    cur_long = setting_tbl[p][1];
    cur_win = setting_tbl[p][2];
    cur_hold = setting_tbl[p][6];
  endtask

  // Press, hold, release, with an occasional bounce on the press.
  task automatic press_release();
    int settle_ticks;
    settle_ticks = (cur_deb > 40) ? 40 : cur_deb;
    send_event(OP_SWITCH, 1'b0, rbit(), rbit());
    if ($urandom_range(3) == 0) begin
      tick_burst(span(cur_deb));
      send_event(OP_SWITCH, 1'b1, rbit(), rbit());
      send_event(OP_SWITCH, 1'b0, rbit(), rbit());
    end
    tick_burst(settle_ticks + span(cur_long + 3));
    send_event(OP_SWITCH, 1'b1, rbit(), rbit());
    tick_burst(settle_ticks + span(cur_win + 3));
  endtask

  // A few detents in one direction through the Gray sequence; sometimes a
  // phase is replaced by a random one to break the sequence.
  task automatic turn_knob();
    logic [1:0] cw [4];
    logic [1:0] ph;
    bit         dir;
    int         detents;
    cw = '{2'b10, 2'b00, 2'b01, 2'b11};
    dir = 1'($urandom_range(1));
    detents = $urandom_range(4, 1);
    repeat (detents) begin
      for (int k = 0; k < 4; k++) begin
        ph = dir ? cw[k] : cw[(k == 3) ? 3 : 2 - k];
        if ($urandom_range(9) == 0) ph = 2'($urandom_range(3));
        send_event(OP_PINS, rbit(), ph[0], ph[1]);
      end
      if ($urandom_range(1)) tick_burst(span(cur_hold + 2));
    end
  endtask

  initial begin
    int phase_start;
    int pick;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with small timing limits.
    apply_setting(7);
    // Unused opcode and pins both high are ignored.
    send_event(OP_UNUSED, 1'b1, 1'b1, 1'b1);
    send_event(OP_PINS, 1'b0, 1'b1, 1'b1);
    // First detent is swallowed; both low clears the upper scan bits.
    send_event(OP_PINS, 1'b0, 1'b1, 1'b0);
    send_event(OP_PINS, 1'b1, 1'b0, 1'b0);
    send_event(OP_PINS, 1'b0, 1'b0, 1'b1);
    send_event(OP_PINS, 1'b0, 1'b0, 1'b1);
    send_event(OP_PINS, 1'b1, 1'b1, 1'b0);
    // Release, press past the minimum, then release again; the final release is not yet debounced.
    send_event(OP_SWITCH, 1'b1, 1'b0, 1'b0);
    tick_burst(4);
    send_event(OP_SWITCH, 1'b0, 1'b1, 1'b1);
    tick_burst(9);
    send_event(OP_SWITCH, 1'b1, 1'b0, 1'b1);
    tick_burst(3);

    // Random part: one register setting per phase, idling rotates.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      apply_setting(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      phase_start = items_sent;
      item_limit = phase_start + ITEMS_PER_PHASE;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 40) press_release();
        else if (pick < 75) turn_knob();
        else if (pick < 90) tick_burst($urandom_range(10, 1));
        else send_event(2'($urandom_range(3)), rbit(), rbit(), rbit());
        if (p == 1 && items_sent - phase_start >= ITEMS_PER_PHASE / 2 &&
            items_sent - phase_start < ITEMS_PER_PHASE / 2 + 8) begin
          wait_results();
        end else if ($urandom_range(49) == 0) begin
          wait_results();
        end
      end
    end

    // Drain, then keep watching for anything unexpected before the final check.
    wait_results();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
